@@ hw/rtl/sample_entropy_counter_top_macros.svh @@
// Assertion helpers used by the RTL file sample_entropy_counter_top.sv
`ifndef SAMPLE_ENTROPY_COUNTER_TOP_MACROS_SVH
`define SAMPLE_ENTROPY_COUNTER_TOP_MACROS_SVH

// same-cycle implication
`define SEC_CHECK(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define SEC_CHECK_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hw/rtl/sec_pkg.sv @@
`timescale 1ns / 1ps
package sec_pkg;

    localparam int CNT_W = 19;
    localparam int LOG_W = 20;
    localparam logic [27:0] LN2_Q28 = 28'd186065280;
    localparam logic [LOG_W-1:0] LOG_MAX = {LOG_W{1'b1}};

    localparam logic REG_TEMPLATE_LENGTH = 1'b0;
    localparam logic REG_TOLERANCE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_FINITE    = 2'd0,
        STATUS_INFINITE  = 2'd1,
        STATUS_UNDEFINED = 2'd2
    } status_t;

    typedef struct packed {
        logic shift;
        logic active;
    } cell_ctl_t;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] value;
    } log_res_t;

endpackage

@@ hw/rtl/sec_ram.sv @@
`timescale 1ns / 1ps
module sec_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/sec_cell.sv @@
`timescale 1ns / 1ps
module sec_cell import sec_pkg::*; (
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  logic      bit_in,
    input  logic      run_in,
    output logic      bit_out,
    output logic      run_out
);

    logic bit_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            bit_reg <= bit_in;
        end
    end

    assign bit_out = bit_reg;
    assign run_out = run_in & (bit_reg | ~ctl.active);

endmodule

@@ hw/rtl/sec_log.sv @@
`timescale 1ns / 1ps
module sec_log import sec_pkg::*; #(
    parameter int CW = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [CW-1:0] num,
    input  logic [CW-1:0] den,
    output log_res_t      res
);

    localparam int EW = $clog2(CW);
    localparam int LW = EW + 30;
    localparam int PW = LW + 28;
    localparam int HW = LW - 16;
    localparam logic [PW:0] HALF = (PW+1)'(1) << 41;

    typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQR, L_MLO, L_MHI, L_RND} lst_t;

    lst_t            st_reg;
    logic [CW-1:0]   v_reg;
    logic [CW-1:0]   den_reg;
    logic [EW-1:0]   s_reg;
    logic [EW-1:0]   e_reg;
    logic [30:0]     y_reg;
    logic [29:0]     frac_reg;
    logic [4:0]      b_reg;
    logic            sel_reg;
    logic [LW-1:0]   la_reg;
    logic [LW-1:0]   d_reg;
    logic [PW-1:0]   p_reg;
    log_res_t        res_reg;

    logic [61:0]     sq;
    logic [31:0]     yn;
    logic [CW+30:0]  wide;
    logic [29:0]     frac_next;
    logic [LW-1:0]   log_cur;
    logic [43:0]     lo_prod;
    logic [HW+27:0]  hi_prod;
    logic [PW:0]     rnd;
    logic [PW:0]     sh;

    always_comb
    begin
        sq        = {31'b0, y_reg} * {31'b0, y_reg};
        yn        = sq[61:30];
        wide      = {v_reg, 31'b0};
        frac_next = frac_reg | (yn[31] ? (30'(1) << b_reg) : 30'(0));
        log_cur   = {e_reg, frac_next};
        lo_prod   = {28'b0, d_reg[15:0]} * {16'b0, LN2_Q28};
        hi_prod   = (HW+28)'(d_reg[LW-1:16]) * (HW+28)'(LN2_Q28);
        rnd       = {1'b0, p_reg} + HALF;
        sh        = rnd >> 42;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= L_IDLE;
            res_reg.done <= 1'b0;
        end
        else
        begin
            res_reg.done <= (st_reg == L_RND);
            case (st_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        v_reg   <= num;
                        den_reg <= den;
                        s_reg   <= '0;
                        sel_reg <= 1'b0;
                        st_reg  <= L_NORM;
                    end
                end
                L_NORM:
                begin
                    if (v_reg[CW-1])
                    begin
                        y_reg    <= wide[CW+30:CW];
                        e_reg    <= EW'(CW-1) - s_reg;
                        frac_reg <= '0;
                        b_reg    <= 5'd29;
                        st_reg   <= L_SQR;
                    end
                    else
                    begin
                        v_reg <= v_reg << 1;
                        s_reg <= s_reg + 1'b1;
                    end
                end
                L_SQR:
                begin
                    y_reg    <= yn[31] ? yn[31:1] : yn[30:0];
                    frac_reg <= frac_next;
                    b_reg    <= b_reg - 1'b1;
                    if (b_reg == 5'd0)
                    begin
                        if (!sel_reg)
                        begin
                            la_reg  <= log_cur;
                            sel_reg <= 1'b1;
                            v_reg   <= den_reg;
                            s_reg   <= '0;
                            st_reg  <= L_NORM;
                        end
                        else
                        begin
                            d_reg  <= (la_reg > log_cur) ? la_reg - log_cur : '0;
                            st_reg <= L_MLO;
                        end
                    end
                end
                L_MLO:
                begin
                    p_reg  <= PW'(lo_prod);
                    st_reg <= L_MHI;
                end
                L_MHI:
                begin
                    p_reg  <= p_reg + (PW'(hi_prod) << 16);
                    st_reg <= L_RND;
                end
                L_RND:
                begin
                    res_reg.value <= (sh > (PW+1)'(LOG_MAX)) ? LOG_MAX : LOG_W'(sh);
                    st_reg        <= L_IDLE;
                end
                default:
                begin
                    st_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign res = res_reg;

endmodule

@@ hw/rtl/sample_entropy_counter_top.sv @@
`timescale 1ns / 1ps
// Loading takes one sample beat per cycle; the beat flagged last ends the series.
// Pair scan: one RAM read pair per cycle, N-d read pairs for each lag d = 1..N-m-1,
// fed through the registered RAM read into the match cells, then the iterative
// log unit (30 squarings per count) runs when status is finite.
// The result sits in an output register; loading of the next series resumes once that register is free or being read.
// Reset (rst_n low, asynchronous) empties the series, clears the flag, m=2, r=0.
`include "sample_entropy_counter_top_macros.svh"
module sample_entropy_counter_top import sec_pkg::*; #(
    parameter int MAX_SAMPLES  = 1024,
    parameter int MAX_TEMPLATE = 8,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // count_m, count_m_plus_one, log_ratio, status, overflowed
    output logic [63:0]                         m_tdata,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [15:0]                         cfg_data
);

    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int NW   = AW + 1;
    localparam int CW   = 2 * AW;
    localparam int MW   = $clog2(MAX_TEMPLATE + 1);
    localparam int DW   = SAMPLE_BITS + 1;
    localparam int CMPW = (DW > 16) ? DW : 16;

    typedef enum logic [2:0] {ST_LOAD, ST_SCAN, ST_DRAIN, ST_LOG, ST_WAIT, ST_FINISH} st_t;

    st_t              st_reg;
    logic [3:0]       tl_reg;
    logic [15:0]      tol_reg;
    logic [NW-1:0]    count_reg;
    logic             ovf_reg;
    logic [MW-1:0]    m_reg;
    logic [AW-1:0]    t_reg;
    logic [AW-1:0]    d_reg;
    logic [AW-1:0]    lim_reg;
    logic             p_vld_reg;
    logic [AW-1:0]    p_t_reg;
    logic [CW-1:0]    cnt_m_reg;
    logic [CW-1:0]    cnt_m1_reg;
    status_t          status_reg;
    logic [LOG_W-1:0] lr_reg;
    logic             m_tvalid_reg;
    logic [63:0]      m_tdata_reg;
    logic             log_start_reg;

    logic                   room;
    logic [NW-1:0]          n_fin;
    logic [MW-1:0]          m_sat;
    logic [AW-1:0]          t_end;
    logic [SAMPLE_BITS-1:0] a_data;
    logic [SAMPLE_BITS-1:0] b_data;
    logic signed [DW-1:0]   diff;
    logic [DW-1:0]          absd;
    logic                   match;
    logic                   win_ok;
    log_res_t               log_res;
    logic                   s_fire;
    logic                   wr_en;

    logic bits [MAX_TEMPLATE];
    logic run  [MAX_TEMPLATE+1];

    assign s_tready = (st_reg == ST_LOAD);
    assign s_fire   = s_tvalid && s_tready;
    assign room     = count_reg < NW'(MAX_SAMPLES);
    assign wr_en    = s_fire && room;
    assign n_fin    = count_reg + NW'(room);
    assign m_sat    = (tl_reg > MAX_TEMPLATE) ? MW'(MAX_TEMPLATE) : MW'(tl_reg);
    assign t_end    = AW'(count_reg - NW'(d_reg) - NW'(1));

    sec_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_ram_a (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_tdata[SAMPLE_BITS-1:0]),
        .raddr (t_reg),
        .rdata (a_data)
    );

    sec_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_ram_b (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_tdata[SAMPLE_BITS-1:0]),
        .raddr (AW'(t_reg + d_reg)),
        .rdata (b_data)
    );

    always_comb
    begin
        diff  = $signed({a_data[SAMPLE_BITS-1], a_data})
              - $signed({b_data[SAMPLE_BITS-1], b_data});
        absd  = diff[DW-1] ? DW'(-diff) : DW'(diff);
        match = CMPW'(absd) <= CMPW'(tol_reg);
    end

    assign run[0] = 1'b1;

    for (genvar k = 0; k < MAX_TEMPLATE; k++)
    begin : g_cell
        cell_ctl_t ctl;
        assign ctl.shift  = p_vld_reg;
        assign ctl.active = k < int'(m_reg);
        sec_cell u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .bit_in  ((k == 0) ? match : bits[(k == 0) ? 0 : k-1]),
            .run_in  (run[k]),
            .bit_out (bits[k]),
            .run_out (run[k+1])
        );
    end

    assign win_ok = run[MAX_TEMPLATE];

    sec_log #(.CW(CW)) u_log (
        .clk   (clk),
        .rst_n (rst_n),
        .start (log_start_reg),
        .num   (cnt_m_reg),
        .den   (cnt_m1_reg),
        .res   (log_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_LOAD;
            tl_reg        <= 4'd2;
            tol_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            p_vld_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            log_start_reg <= 1'b0;
            cnt_m_reg     <= '0;
            cnt_m1_reg    <= '0;
        end
        else
        begin
            log_start_reg <= (st_reg == ST_LOG) && (cnt_m_reg != '0) && (cnt_m1_reg != '0);
            p_vld_reg     <= (st_reg == ST_SCAN);
            if (cfg_we)
            begin
                if (cfg_index == REG_TEMPLATE_LENGTH)
                begin
                    tl_reg <= cfg_data[3:0];
                end
                else
                begin
                    tol_reg <= cfg_data;
                end
            end
            if (m_tvalid_reg && m_tready && (st_reg != ST_FINISH))
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (p_vld_reg && (p_t_reg >= AW'(m_reg)) && win_ok)
            begin
                cnt_m_reg <= cnt_m_reg + 1'b1;
                if (match)
                begin
                    cnt_m1_reg <= cnt_m1_reg + 1'b1;
                end
            end
            case (st_reg)
                ST_LOAD:
                begin
                    if (s_fire)
                    begin
                        count_reg <= n_fin;
                        if (!room)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast)
                        begin
                            m_reg      <= m_sat;
                            cnt_m_reg  <= '0;
                            cnt_m1_reg <= '0;
                            t_reg      <= '0;
                            d_reg      <= AW'(1);
                            lim_reg    <= AW'(n_fin - NW'(m_sat) - NW'(1));
                            if ((NW+1)'(n_fin) >= (NW+1)'(m_sat) + (NW+1)'(2))
                            begin
                                st_reg <= ST_SCAN;
                            end
                            else
                            begin
                                st_reg <= ST_LOG;
                            end
                        end
                    end
                end
                ST_SCAN:
                begin
                    p_t_reg <= t_reg;
                    if (t_reg == t_end)
                    begin
                        t_reg <= '0;
                        d_reg <= d_reg + 1'b1;
                        if (d_reg == lim_reg)
                        begin
                            st_reg <= ST_DRAIN;
                        end
                    end
                    else
                    begin
                        t_reg <= t_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    st_reg <= ST_LOG;
                end
                ST_LOG:
                begin
                    lr_reg <= '0;
                    if (cnt_m_reg == '0)
                    begin
                        status_reg <= STATUS_UNDEFINED;
                        st_reg     <= ST_FINISH;
                    end
                    else if (cnt_m1_reg == '0)
                    begin
                        status_reg <= STATUS_INFINITE;
                        st_reg     <= ST_FINISH;
                    end
                    else
                    begin
                        status_reg <= STATUS_FINITE;
                        st_reg     <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    if (log_res.done)
                    begin
                        lr_reg <= log_res.value;
                        st_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {3'b0, ovf_reg, status_reg, lr_reg,
                                         CNT_W'(cnt_m1_reg), CNT_W'(cnt_m_reg)};
                        count_reg    <= '0;
                        ovf_reg      <= 1'b0;
                        st_reg       <= ST_LOAD;
                    end
                    else
                    begin
                        m_tvalid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    st_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SEC_CHECK(a_cnt_order, 1'b1, cnt_m1_reg <= cnt_m_reg, "m+1 count above m count")
    `SEC_CHECK(a_scan_range, st_reg == ST_SCAN, NW'(t_reg) + NW'(d_reg) < count_reg, "scan read past series end")
    `SEC_CHECK_NEXT(a_last_stops, s_fire && s_tlast, !s_tready, "beat taken after last")

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import sec_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int TEMPLATE_CAP = 8;
    localparam int WATCHDOG_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    typedef struct packed {
        logic [CNT_W-1:0] count_m;
        logic [CNT_W-1:0] count_m1;
        logic [LOG_W-1:0] log_ratio;
        status_t          status;
        logic             overflowed;
    } entropy_res_t;

    entropy_res_t      entropy_q[$];
    logic signed [15:0] series_q[$];
    logic              series_dropped;
    logic [3:0]        cur_m;
    logic [15:0]       cur_r;
    int                mismatch_count;
    int                hold_cycles;
    int                idle_cycles;

    sample_entropy_counter_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint unsigned log2_q30(longint unsigned v);
        int unsigned e;
        longint unsigned y;
        longint unsigned frac;
        e = 0;
        frac = 0;
        while (e < 63 && (v >> (e + 1)) != 0)
            e++;
        y = (e <= 30) ? (v << (30 - e)) : (v >> (e - 30));
        for (int b = 29; b >= 0; b--)
        begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30))
            begin
                y = y >> 1;
                frac |= 64'd1 << b;
            end
        end
        return (longint'(e) << 30) | frac;
    endfunction

    function automatic bit within_tol(int a, int b);
        int d;
        d = a - b;
        if (d < 0)
            d = -d;
        return d <= int'(cur_r);
    endfunction

    function automatic entropy_res_t predict_entropy();
        entropy_res_t    res;
        longint unsigned cm;
        longint unsigned cm1;
        longint unsigned a;
        longint unsigned b;
        longint unsigned d;
        longint unsigned lr;
        int              n;
        int              m;
        bit              eq;
        cm = 0;
        cm1 = 0;
        lr = 0;
        n = series_q.size();
        m = (cur_m > TEMPLATE_CAP) ? TEMPLATE_CAP : int'(cur_m);
        if (n >= 2 && n > m)
        begin
            for (int i = 0; i < n - m; i++)
            begin
                for (int j = i + 1; j < n - m; j++)
                begin
                    eq = 1'b1;
                    for (int k = 0; k < m && eq; k++)
                        eq = within_tol(series_q[i+k], series_q[j+k]);
                    if (eq)
                    begin
                        cm++;
                        if (within_tol(series_q[i+m], series_q[j+m]))
                            cm1++;
                    end
                end
            end
        end
        if (n < 2 || cm == 0)
            res.status = STATUS_UNDEFINED;
        else if (cm1 == 0)
            res.status = STATUS_INFINITE;
        else
        begin
            a = log2_q30(cm);
            b = log2_q30(cm1);
            d = (a > b) ? a - b : 0;
            lr = (d * 64'(LN2_Q28) + (64'd1 << 41)) >> 42;
            if (lr > 64'(LOG_MAX))
                lr = 64'(LOG_MAX);
            res.status = STATUS_FINITE;
        end
        res.count_m = cm[CNT_W-1:0];
        res.count_m1 = cm1[CNT_W-1:0];
        res.log_ratio = lr[LOG_W-1:0];
        res.overflowed = series_dropped;
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on %s: got %0d, want %0d at %0t", field, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic send_sample(logic signed [15:0] value, logic last);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if ($urandom_range(0, 60) == 0)
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        if (series_q.size() < STORE_DEPTH)
            series_q.push_back(value);
        else
            series_dropped = 1'b1;
        if (last)
        begin
            entropy_q.push_back(predict_entropy());
            series_q.delete();
            series_dropped = 1'b0;
        end
    endtask

    task automatic wait_idle();
        @(posedge clk);
        s_tvalid <= 1'b0;
        while (entropy_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TEMPLATE_LENGTH)
            cur_m = value[3:0];
        else
            cur_r = value;
    endtask

    task automatic send_series(int len, int base, int spread);
        for (int i = 0; i < len; i++)
            send_sample(16'(base + $signed($urandom_range(0, spread))), i == len - 1);
    endtask

    task automatic test_directed();
        write_cfg(REG_TEMPLATE_LENGTH, 16'd2);
        write_cfg(REG_TOLERANCE, 16'd0);
        send_sample(16'sd5, 1'b1);
        send_series(2, 7, 0);
        send_series(8, 100, 0);
        for (int i = 0; i < 8; i++)
            send_sample((i % 2) ? 16'sd1 : 16'sd0, i == 7);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd2, 1'b1);
        write_cfg(REG_TOLERANCE, 16'hFFFF);
        for (int i = 0; i < 6; i++)
            send_sample((i % 2) ? 16'sh7FFF : 16'sh8000, i == 5);
        write_cfg(REG_TEMPLATE_LENGTH, 16'd0);
        write_cfg(REG_TOLERANCE, 16'd3);
        send_series(6, -10, 8);
        write_cfg(REG_TEMPLATE_LENGTH, 16'd15);
        send_series(12, 0, 1);
        write_cfg(REG_TEMPLATE_LENGTH, 16'd8);
        send_series(9, 0, 0);
    endtask

    task automatic test_overflow();
        write_cfg(REG_TEMPLATE_LENGTH, 16'd8);
        write_cfg(REG_TOLERANCE, 16'd1);
        send_series(STORE_DEPTH + 5, -3, 5);
    endtask

    task automatic test_backpressure();
        write_cfg(REG_TEMPLATE_LENGTH, 16'd1);
        write_cfg(REG_TOLERANCE, 16'd2);
        @(negedge clk);
        hold_cycles = 300;
        @(posedge clk);
        for (int s = 0; s < 6; s++)
            send_series(5, 0, 4);
    endtask

    task automatic test_random();
        int len;
        for (int s = 0; s < 28; s++)
        begin
            if (s % 5 == 0)
            begin
                write_cfg(REG_TEMPLATE_LENGTH, 16'($urandom_range(0, 15)));
                case ($urandom_range(0, 3))
                    0: write_cfg(REG_TOLERANCE, 16'd0);
                    1: write_cfg(REG_TOLERANCE, 16'hFFFF);
                    default: write_cfg(REG_TOLERANCE, 16'($urandom_range(0, 40)));
                endcase
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 20);
            if ($urandom_range(0, 4) == 0)
                for (int i = 0; i < len; i++)
                    send_sample(16'($urandom), i == len - 1);
            else
                send_series(len, $signed(16'($urandom)), $urandom_range(0, 30));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 5)
            hold_cycles <= $urandom_range(1, 30);
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        entropy_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (entropy_q.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = entropy_q.pop_front();
                if (m_tdata[18:0] !== want.count_m)
                    report_mismatch("count_m", m_tdata[18:0], want.count_m);
                if (m_tdata[37:19] !== want.count_m1)
                    report_mismatch("count_m_plus_one", m_tdata[37:19], want.count_m1);
                if (m_tdata[57:38] !== want.log_ratio)
                    report_mismatch("log_ratio", m_tdata[57:38], want.log_ratio);
                if (m_tdata[59:58] !== want.status)
                    report_mismatch("status", m_tdata[59:58], want.status);
                if (m_tdata[60] !== want.overflowed)
                    report_mismatch("overflowed", m_tdata[60], want.overflowed);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        cur_m = 4'd2;
        cur_r = 16'd0;
        series_dropped = 1'b0;
        mismatch_count = 0;
        hold_cycles = 0;
        idle_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        test_overflow();
        wait_idle();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && entropy_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
